// ===== hdl/vvc_nal_rtp_packetizer_macros.svh =====
// Assertion helpers for the packetizer checker.
`ifndef VVC_NAL_RTP_PACKETIZER_MACROS_SVH
`define VVC_NAL_RTP_PACKETIZER_MACROS_SVH

// Checked only outside reset.
`define VNRP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vnrp assertion failed");

// Checked in every cycle, reset included.
`define VNRP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("vnrp assertion failed");

`endif

// ===== hdl/vnrp_pkg.sv =====
package vnrp_pkg;

  localparam int SIZE_WIDTH = 16;
  localparam logic [15:0] SIZE_MASK = 16'((1 << SIZE_WIDTH) - 1);

  localparam int MAX_RES = 8;
  localparam int QDEPTH  = 4;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_AGG    = 2'd2;
  localparam logic [1:0] MODE_FRAG   = 2'd3;

  localparam logic [4:0] AP_TYPE = 5'd28;
  localparam logic [4:0] FU_TYPE = 5'd29;

  localparam logic [15:0] LIMIT_MIN   = 16'd16;
  localparam logic [15:0] LIMIT_RESET = 16'd1400;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        start;
    logic [15:0] seq;
  } res_t;

  // One accepted request's results, in order; cnt is 1..MAX_RES.
  typedef struct packed {
    res_t [MAX_RES-1:0] r;
    logic [3:0]         cnt;
  } rec_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [7:0] data, logic start,
                                  logic [15:0] seq);
    res_t x;
    x.kind  = kind;
    x.data  = (kind == KIND_DATA) ? data : 8'd0;
    x.start = start;
    x.seq   = start ? seq : 16'd0;
    return x;
  endfunction

endpackage

// ===== hdl/vnrp_front.sv =====
module vnrp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          op,
  input  logic [7:0]    nal_byte,
  input  logic          unit_first,
  input  logic [15:0]   unit_size,
  input  logic          has_next,
  input  logic [15:0]   next_size,
  input  logic          q_full,
  output logic          q_push,
  output vnrp_pkg::rec_t q_rec
);
  import vnrp_pkg::*;

  logic [15:0] payload_limit;
  logic [15:0] byte_index, unit_length, aggregate_bytes, fragment_bytes, next_seq, next_raw;
  logic [2:0]  prefix_length, temporal_id;
  logic [7:0]  held_header;
  logic [1:0]  unit_mode;
  logic [4:0]  unit_type;
  logic        active, pkt_open, next_valid;

  logic [15:0] byte_index_next, unit_length_next, aggregate_bytes_next;
  logic [15:0] fragment_bytes_next, next_seq_next, next_raw_next;
  logic [2:0]  prefix_length_next, temporal_id_next;
  logic [7:0]  held_header_next;
  logic [1:0]  unit_mode_next;
  logic [4:0]  unit_type_next;
  logic        active_next, pkt_open_next, next_valid_next;

  res_t [MAX_RES-1:0] r;
  logic [3:0]  n;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [15:0] lim, len, b, maxsz;
    logic        last, s, e;
    lim   = (payload_limit < LIMIT_MIN) ? LIMIT_MIN : payload_limit;
    maxsz = lim - 16'd3;
    len   = 16'd0;
    b     = 16'd0;
    last  = 1'b0;
    s     = 1'b0;
    e     = 1'b0;
    r = '0;
    n = 4'd0;
    byte_index_next      = byte_index;
    unit_length_next     = unit_length;
    aggregate_bytes_next = aggregate_bytes;
    fragment_bytes_next  = fragment_bytes;
    next_seq_next        = next_seq;
    next_raw_next        = next_raw;
    prefix_length_next   = prefix_length;
    temporal_id_next     = temporal_id;
    held_header_next     = held_header;
    unit_mode_next       = unit_mode;
    unit_type_next       = unit_type;
    active_next          = active;
    pkt_open_next        = pkt_open;
    next_valid_next      = next_valid;

    // abandon any unit in progress on a flush or a new unit
    if (op || unit_first) begin
      if (active_next) begin
        if (pkt_open_next) begin
          r[n[2:0]] = mk_res(KIND_END, 8'd0, 1'b0, next_seq_next); n = n + 4'd1;
        end
        if (unit_mode_next == MODE_AGG && aggregate_bytes_next != 16'd0) begin
          r[n[2:0]] = mk_res(KIND_END, 8'd0, 1'b0, next_seq_next); n = n + 4'd1;
          aggregate_bytes_next = 16'd0;
        end
      end
      pkt_open_next  = 1'b0;
      active_next    = 1'b0;
      unit_mode_next = MODE_NONE;
    end

    if (op) begin
      if (aggregate_bytes_next != 16'd0) begin
        r[n[2:0]] = mk_res(KIND_END, 8'd0, 1'b0, next_seq_next); n = n + 4'd1;
        aggregate_bytes_next = 16'd0;
      end
    end else begin
      if (unit_first) begin
        unit_length_next    = unit_size & SIZE_MASK;
        next_valid_next     = has_next;
        next_raw_next       = next_size & SIZE_MASK;
        byte_index_next     = 16'd0;
        prefix_length_next  = 3'd0;
        fragment_bytes_next = 16'd0;
        active_next         = (unit_size & SIZE_MASK) != 16'd0;
      end
      if (active_next) begin
        b = byte_index_next;
        if (prefix_length_next == 3'd0) begin
          if (b == 16'd2 && nal_byte == 8'd1) begin
            prefix_length_next = 3'd3;
          end else if (b == 16'd3) begin
            if (nal_byte == 8'd1) begin
              prefix_length_next = 3'd4;
            end else begin
              r[n[2:0]] = mk_res(KIND_BAD, 8'd0, 1'b0, next_seq_next); n = n + 4'd1;
              active_next = 1'b0;
            end
          end
          if (prefix_length_next != 3'd0 &&
              {1'b0, unit_length_next} < 17'(prefix_length_next) + 17'd2)
            active_next = 1'b0;
        end else if (b == 16'(prefix_length_next)) begin
          held_header_next = nal_byte;
        end else if (b == 16'(prefix_length_next) + 16'd1) begin
          // decision on the second header byte
          len = unit_length_next - 16'(prefix_length_next);
          unit_type_next   = nal_byte[7:3];
          temporal_id_next = nal_byte[2:0];
          if (len >= lim) begin
            if (aggregate_bytes_next != 16'd0) begin
              r[n[2:0]] = mk_res(KIND_END, 8'd0, 1'b0, next_seq_next); n = n + 4'd1;
              aggregate_bytes_next = 16'd0;
            end
            unit_mode_next      = MODE_FRAG;
            fragment_bytes_next = 16'd0;
          end else begin
            if (aggregate_bytes_next != 16'd0 &&
                18'(aggregate_bytes_next) + 18'd2 + 18'(len) > 18'(lim)) begin
              r[n[2:0]] = mk_res(KIND_END, 8'd0, 1'b0, next_seq_next); n = n + 4'd1;
              aggregate_bytes_next = 16'd0;
            end
            if (aggregate_bytes_next == 16'd0 && next_valid_next &&
                18'd6 + 18'(len) + 18'(next_raw_next) <= 18'(lim)) begin
              r[n[2:0]] = mk_res(KIND_DATA, held_header_next, 1'b1, next_seq_next);
              n = n + 4'd1;
              next_seq_next = next_seq_next + 16'd1;
              r[n[2:0]] = mk_res(KIND_DATA, {AP_TYPE, temporal_id_next}, 1'b0, 16'd0);
              n = n + 4'd1;
              r[n[2:0]] = mk_res(KIND_DATA, len[15:8], 1'b0, 16'd0); n = n + 4'd1;
              r[n[2:0]] = mk_res(KIND_DATA, len[7:0], 1'b0, 16'd0); n = n + 4'd1;
              r[n[2:0]] = mk_res(KIND_DATA, held_header_next, 1'b0, 16'd0); n = n + 4'd1;
              r[n[2:0]] = mk_res(KIND_DATA, nal_byte, 1'b0, 16'd0); n = n + 4'd1;
              aggregate_bytes_next = len + 16'd4;
              unit_mode_next = MODE_AGG;
            end else if (aggregate_bytes_next != 16'd0) begin
              r[n[2:0]] = mk_res(KIND_DATA, len[15:8], 1'b0, 16'd0); n = n + 4'd1;
              r[n[2:0]] = mk_res(KIND_DATA, len[7:0], 1'b0, 16'd0); n = n + 4'd1;
              r[n[2:0]] = mk_res(KIND_DATA, held_header_next, 1'b0, 16'd0); n = n + 4'd1;
              r[n[2:0]] = mk_res(KIND_DATA, nal_byte, 1'b0, 16'd0); n = n + 4'd1;
              aggregate_bytes_next = aggregate_bytes_next + 16'd2 + len;
              unit_mode_next = MODE_AGG;
            end else begin
              r[n[2:0]] = mk_res(KIND_DATA, held_header_next, 1'b1, next_seq_next);
              n = n + 4'd1;
              next_seq_next = next_seq_next + 16'd1;
              r[n[2:0]] = mk_res(KIND_DATA, nal_byte, 1'b0, 16'd0); n = n + 4'd1;
              pkt_open_next  = 1'b1;
              unit_mode_next = MODE_SINGLE;
              if (len == 16'd2) begin
                r[n[2:0]] = mk_res(KIND_END, 8'd0, 1'b0, 16'd0); n = n + 4'd1;
                pkt_open_next = 1'b0;
              end
            end
          end
        end else begin
          // body byte
          last = (17'(b) + 17'd1) == 17'(unit_length_next);
          case (unit_mode_next)
            MODE_SINGLE: begin
              r[n[2:0]] = mk_res(KIND_DATA, nal_byte, 1'b0, 16'd0); n = n + 4'd1;
              if (last) begin
                r[n[2:0]] = mk_res(KIND_END, 8'd0, 1'b0, 16'd0); n = n + 4'd1;
                pkt_open_next = 1'b0;
              end
            end
            MODE_AGG: begin
              r[n[2:0]] = mk_res(KIND_DATA, nal_byte, 1'b0, 16'd0); n = n + 4'd1;
            end
            MODE_FRAG: begin
              if (fragment_bytes_next == 16'd0) begin
                s = (17'(b) == 17'(prefix_length_next) + 17'd2);
                e = (unit_length_next - b) <= maxsz;
                r[n[2:0]] = mk_res(KIND_DATA, held_header_next, 1'b1, next_seq_next);
                n = n + 4'd1;
                next_seq_next = next_seq_next + 16'd1;
                r[n[2:0]] = mk_res(KIND_DATA, {FU_TYPE, temporal_id_next}, 1'b0, 16'd0);
                n = n + 4'd1;
                r[n[2:0]] = mk_res(KIND_DATA, {s, e, 1'b0, unit_type_next}, 1'b0, 16'd0);
                n = n + 4'd1;
                pkt_open_next = 1'b1;
              end
              r[n[2:0]] = mk_res(KIND_DATA, nal_byte, 1'b0, 16'd0); n = n + 4'd1;
              fragment_bytes_next = fragment_bytes_next + 16'd1;
              if (fragment_bytes_next >= maxsz || last) begin
                r[n[2:0]] = mk_res(KIND_END, 8'd0, 1'b0, 16'd0); n = n + 4'd1;
                fragment_bytes_next = 16'd0;
                pkt_open_next = 1'b0;
              end
            end
            default: ;
          endcase
        end
        byte_index_next = byte_index_next + 16'd1;
        if (active_next && byte_index_next >= unit_length_next) begin
          active_next    = 1'b0;
          unit_mode_next = MODE_NONE;
        end
      end
    end
  end

  assign q_push    = accept && (n != 4'd0);
  assign q_rec.r   = r;
  assign q_rec.cnt = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit   <= LIMIT_RESET;
      byte_index      <= '0;
      unit_length     <= '0;
      aggregate_bytes <= '0;
      fragment_bytes  <= '0;
      next_seq        <= '0;
      next_raw        <= '0;
      prefix_length   <= '0;
      temporal_id     <= '0;
      held_header     <= '0;
      unit_mode       <= MODE_NONE;
      unit_type       <= '0;
      active          <= 1'b0;
      pkt_open        <= 1'b0;
      next_valid      <= 1'b0;
    end else begin
      if (cfg_we) payload_limit <= cfg_data;
      if (accept) begin
        byte_index      <= byte_index_next;
        unit_length     <= unit_length_next;
        aggregate_bytes <= aggregate_bytes_next;
        fragment_bytes  <= fragment_bytes_next;
        next_seq        <= next_seq_next;
        next_raw        <= next_raw_next;
        prefix_length   <= prefix_length_next;
        temporal_id     <= temporal_id_next;
        held_header     <= held_header_next;
        unit_mode       <= unit_mode_next;
        unit_type       <= unit_type_next;
        active          <= active_next;
        pkt_open        <= pkt_open_next;
        next_valid      <= next_valid_next;
      end
    end
  end

endmodule

// ===== hdl/vnrp_queue.sv =====
module vnrp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vnrp_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output vnrp_pkg::rec_t head
);
  import vnrp_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  rec_t           slots [QDEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    count;

  assign full  = count == (PW+1)'(QDEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ===== hdl/vnrp_back.sv =====
module vnrp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  vnrp_pkg::rec_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output vnrp_pkg::res_t out_res,
  output logic           out_last
);
  import vnrp_pkg::*;

  logic [2:0] idx;
  logic       load, final_one;

  assign load      = !empty && (!out_valid || out_ready);
  assign final_one = (4'(idx) + 4'd1) == head.cnt;
  assign pop       = load && final_one;

  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= head.r[idx];
      out_last <= final_one;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_one ? 3'd0 : idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/vvc_nal_rtp_packetizer.sv =====
// A result passes through the request queue and the registered output stage to m_axis.
// Throughput: one request per cycle while each yields at most one result and the queue
//   is not full; results leave at one per cycle while m_axis_tready is high.
// A four-entry request queue between classifier and serializer absorbs bursts.
// Reset (rst, synchronous, active high) clears all unit state, the sequence
//   number and the queue, and sets payload_limit to 1400.
module vvc_nal_rtp_packetizer (
  input  logic        clk,
  input  logic        rst,
  // configuration: payload_limit
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // nal_byte[7:0], unit_first[8], unit_size[24:9],
                                     // has_next[25], next_size[41:26], zero[47:42]
  input  logic        s_axis_tuser,  // op: 0 stream byte, 1 flush
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // payload_byte[7:0], packet_start[8],
                                     // seq_number[24:9], zero[31:25]
  output logic [1:0]  m_axis_tuser,  // kind: 0 payload, 1 end of packet, 2 bad start code
  output logic        m_axis_tlast   // last_of_run: final result of a request
);
  import vnrp_pkg::*;

  logic  q_full, q_push, q_empty, q_pop;
  rec_t  q_rec, q_head;
  res_t  out_res;

  // Register writes are always taken; the user must write only while the block is idle (not enforced).
  assign cfg_ready = 1'b1;

  // Front: start-code stripping, packet mode decision and result generation.
  vnrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .op         (s_axis_tuser),
    .nal_byte   (s_axis_tdata[7:0]),
    .unit_first (s_axis_tdata[8]),
    .unit_size  (s_axis_tdata[24:9]),
    .has_next   (s_axis_tdata[25]),
    .next_size  (s_axis_tdata[41:26]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_rec      (q_rec)
  );

  // Queue of per-request result lists.
  vnrp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (q_rec),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back: serialize results into the registered output stage.
  vnrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_res.seq, out_res.start, out_res.data};
  assign m_axis_tuser = out_res.kind;

endmodule

// ===== hdl/vnrp_checker.sv =====
`include "vvc_nal_rtp_packetizer_macros.svh"

module vnrp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  // stalled result holds
  `VNRP_ASSERT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
  // kind code 3 is never produced
  `VNRP_ASSERT(a_kind, clk, rst, m_axis_tvalid |-> m_axis_tuser != 2'd3)
  // non-payload results carry no byte, no start, no sequence number
  `VNRP_ASSERT(a_ctrl_clean, clk, rst, m_axis_tvalid && m_axis_tuser != 2'd0 |-> m_axis_tdata[24:0] == 25'd0)
  // a bad start code is the only result of its request
  `VNRP_ASSERT(a_bad_last, clk, rst, m_axis_tvalid && m_axis_tuser == 2'd2 |-> m_axis_tlast)
  // output is empty right after reset
  `VNRP_ASSERT_ALWAYS(a_reset, clk, rst |=> !m_axis_tvalid)

endmodule

bind vvc_nal_rtp_packetizer vnrp_checker u_vnrp_checker (.*);

// ===== tb/sv/tb_vvc_nal_rtp_packetizer.sv =====
module tb_vvc_nal_rtp_packetizer;
  timeunit 1ns;
  timeprecision 1ps;

  import vnrp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 24;   // queue depth plus output latency, with margin
  localparam int RANDOM_ITEMS   = 160;

  // one packetizer output as seen on m_axis
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        start;
    logic [15:0] seq;
    logic        last;
  } pkt_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  vvc_nal_rtp_packetizer u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Packetizer predictor: mirrors the unit/packet state of the block.
  // ---------------------------------------------------------------------------
  int unsigned limit_reg = LIMIT_RESET;
  int unsigned byte_pos, start_len, raw_len, hdr0, cur_mode;
  int unsigned agg_fill, frag_fill, seq_ctr, nal_type, tid, peer_len;
  bit          in_unit, pkt_open, peer_ok;

  pkt_res_t step_res[$];    // results of the request being predicted
  pkt_res_t pending_res[$]; // expected results not yet seen on m_axis

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int frags_seen = 0;
  int aggs_seen = 0;
  int bad_seen = 0;

  function void emit(logic [1:0] kind, int unsigned b, bit st);
    pkt_res_t r;
    if (step_res.size() >= MAX_RES) return;
    r.kind  = kind;
    r.data  = (kind == KIND_DATA) ? b[7:0] : 8'd0;
    r.start = st;
    r.seq   = st ? seq_ctr[15:0] : 16'd0;
    r.last  = 1'b0;
    step_res = {step_res, r};
    if (st) seq_ctr = (seq_ctr + 1) & 16'hFFFF;
  endfunction

  function void close_aggregate();
    if (agg_fill > 0) begin
      emit(KIND_END, 0, 0);
      agg_fill = 0;
    end
  endfunction

  // unit cut short by a new unit or a flush
  function void drop_unit();
    if (in_unit) begin
      if (pkt_open) emit(KIND_END, 0, 0);
      if (cur_mode == MODE_AGG) close_aggregate();
    end
    pkt_open = 0;
    in_unit  = 0;
    cur_mode = MODE_NONE;
  endfunction

  // packing decision, taken on the second NAL header byte
  function void choose_packing(int unsigned lim, int unsigned hdr1);
    int unsigned len;
    len      = raw_len - start_len;
    nal_type = (hdr1 >> 3) & 5'h1F;
    tid      = hdr1 & 3'h7;
    if (len >= lim) begin
      close_aggregate();
      cur_mode  = MODE_FRAG;
      frag_fill = 0;
      return;
    end
    if (agg_fill > 0 && agg_fill + 2 + len > lim) close_aggregate();
    if (agg_fill == 0 && peer_ok && 6 + len + peer_len <= lim) begin
      emit(KIND_DATA, hdr0, 1);
      emit(KIND_DATA, (AP_TYPE << 3) | tid, 0);
      emit(KIND_DATA, len >> 8, 0);
      emit(KIND_DATA, len, 0);
      emit(KIND_DATA, hdr0, 0);
      emit(KIND_DATA, hdr1, 0);
      agg_fill = 4 + len;
      cur_mode = MODE_AGG;
      aggs_seen++;
    end else if (agg_fill > 0) begin
      emit(KIND_DATA, len >> 8, 0);
      emit(KIND_DATA, len, 0);
      emit(KIND_DATA, hdr0, 0);
      emit(KIND_DATA, hdr1, 0);
      agg_fill += 2 + len;
      cur_mode = MODE_AGG;
    end else begin
      emit(KIND_DATA, hdr0, 1);
      emit(KIND_DATA, hdr1, 0);
      pkt_open = 1;
      cur_mode = MODE_SINGLE;
      if (len == 2) begin
        emit(KIND_END, 0, 0);
        pkt_open = 0;
      end
    end
  endfunction

  function void payload_body(int unsigned lim, int unsigned b);
    int unsigned frag_max;
    bit          fin, s_bit, e_bit;
    fin = (byte_pos + 1 == raw_len);
    if (cur_mode == MODE_SINGLE) begin
      emit(KIND_DATA, b, 0);
      if (fin) begin
        emit(KIND_END, 0, 0);
        pkt_open = 0;
      end
    end else if (cur_mode == MODE_AGG) begin
      emit(KIND_DATA, b, 0);
    end else if (cur_mode == MODE_FRAG) begin
      frag_max = lim - 3;
      if (frag_fill == 0) begin
        s_bit = (byte_pos == start_len + 2);
        e_bit = (raw_len - byte_pos <= frag_max);
        emit(KIND_DATA, hdr0, 1);
        emit(KIND_DATA, (FU_TYPE << 3) | tid, 0);
        emit(KIND_DATA, (s_bit << 7) | (e_bit << 6) | nal_type, 0);
        pkt_open = 1;
        frags_seen++;
      end
      emit(KIND_DATA, b, 0);
      frag_fill++;
      if (frag_fill >= frag_max || fin) begin
        emit(KIND_END, 0, 0);
        frag_fill = 0;
        pkt_open  = 0;
      end
    end
  endfunction

  function void predict_request(bit op, logic [7:0] b, bit first, logic [15:0] usize,
                                bit hn, logic [15:0] nsize);
    int unsigned lim;
    lim = (limit_reg < LIMIT_MIN) ? LIMIT_MIN : limit_reg;
    step_res.delete();
    if (op) begin
      drop_unit();
      close_aggregate();
    end else begin
      if (first) begin
        drop_unit();
        raw_len   = usize & SIZE_MASK;
        peer_ok   = hn;
        peer_len  = nsize & SIZE_MASK;
        byte_pos  = 0;
        start_len = 0;
        frag_fill = 0;
        in_unit   = (raw_len > 0);
      end
      if (in_unit) begin
        if (start_len == 0) begin
          if (byte_pos == 2 && b == 8'd1) start_len = 3;
          else if (byte_pos == 3) begin
            if (b == 8'd1) start_len = 4;
            else begin
              emit(KIND_BAD, 0, 0);
              in_unit = 0;
              bad_seen++;
            end
          end
          if (start_len != 0 && raw_len < start_len + 2) in_unit = 0;
        end else if (byte_pos == start_len) begin
          hdr0 = b;
        end else if (byte_pos == start_len + 1) begin
          choose_packing(lim, b);
        end else begin
          payload_body(lim, b);
        end
        byte_pos = (byte_pos + 1) & 16'hFFFF;
        if (in_unit && byte_pos >= raw_len) begin
          in_unit  = 0;
          cur_mode = MODE_NONE;
        end
      end
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    pending_res = {pending_res, step_res};
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: bursts with random gaps between them.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_request(bit op, logic [7:0] b, bit first, logic [15:0] usize,
                              bit hn, logic [15:0] nsize);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      // mostly short bursts, now and then a long unbroken stretch
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
    end
    burst_left--;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, nsize, hn, usize, first, b};
    do @(posedge clk); while (!s_axis_tready);
    predict_request(op, b, first, usize, hn, nsize);
    items_sent++;
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= 1'b0;
  endtask

  // hold off until every expected result has come out
  task automatic wait_drained();
    go_idle();
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_reg = v;
  endtask

  task automatic send_flush();
    send_request(1'b1, 8'($urandom), 1'($urandom), 16'($urandom), 1'($urandom),
                 16'($urandom));
  endtask

  // One annex-B unit. pfx is 3 or 4, or 0 for a broken start code; body counts
  // the NAL bytes after the start code. nsend < 0 sends all bytes; usize < 0
  // declares the true size.
  task automatic send_unit(int pfx, int body, bit hn, int nsize, int nsend = -1,
                           int usize = -1);
    int         total, plen;
    logic [7:0] b;
    logic [15:0] dsize;
    plen  = (pfx == 0) ? 4 : pfx;
    total = plen + body;
    dsize = (usize < 0) ? 16'(total) : 16'(usize);
    if (nsend < 0) nsend = total;
    for (int i = 0; i < nsend; i++) begin
      if (i < plen - 1) b = 8'd0;
      else if (i == plen - 1) b = 8'd1;
      else b = 8'($urandom);
      if (pfx == 0 && (i == 2 || i == 3)) b = 8'($urandom_range(2, 255));
      if (i == 0)
        send_request(1'b0, b, 1'b1, dsize, hn, 16'(nsize));
      else  // sideband fields are don't-care past the first byte
        send_request(1'b0, b, 1'b0, 16'($urandom), 1'($urandom), 16'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker with its own stall pattern.
  // ---------------------------------------------------------------------------
  int rx_cyc = 0;
  int idle_cyc = 0;

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0h, expected %0h (result %0d)", what, got, want,
             results_seen);
    errors++;
  endtask

  always @(posedge clk) begin
    pkt_res_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_res.size() == 0) begin
        report("unexpected result kind", m_axis_tuser, 0);
      end else begin
        w = pending_res.pop_front();
        if (m_axis_tuser !== w.kind) report("kind", m_axis_tuser, w.kind);
        if (m_axis_tdata[7:0] !== w.data) report("payload_byte", m_axis_tdata[7:0], w.data);
        if (m_axis_tdata[8] !== w.start) report("packet_start", m_axis_tdata[8], w.start);
        if (m_axis_tdata[24:9] !== w.seq) report("seq_number", m_axis_tdata[24:9], w.seq);
        if (m_axis_tlast !== w.last) report("last_of_run", m_axis_tlast, w.last);
      end
      results_seen++;
    end
    // three stall phases: wide open, light stalls, heavy stalls
    rx_cyc++;
    case ((rx_cyc / 97) % 3)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 9) < 7);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // watchdog: too long without any handshake on either stream
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // singles at the reset limit, both start code lengths, two-byte unit
  task automatic test_single_units();
    send_unit(3, 6, 0, 0);
    send_unit(4, 2, 0, 0);
    send_unit(3, 3, 1, 16'hFFFF);  // next too large to aggregate
  endtask

  // broken prefix, units too short, zero size, stray bytes
  task automatic test_bad_and_short();
    send_unit(0, 3, 0, 0);
    send_unit(3, 1, 0, 0);
    send_unit(4, 0, 0, 0, 2);      // ends before start code settles
    send_request(1'b0, 8'hFF, 1'b1, 16'd0, 1'b1, 16'hFFFF);
    send_request(1'b0, 8'h00, 1'b0, 16'hFFFF, 1'b0, 16'd0);
  endtask

  // aggregation opened, appended, interrupted, flushed
  task automatic test_aggregation();
    send_unit(3, 4, 1, 8);
    send_unit(4, 4, 1, 10);
    send_unit(3, 5, 0, 0);
    send_flush();
    send_unit(3, 5, 1, 8);
    send_unit(3, 6, 0, 0, 5);      // cut short inside the aggregate
    send_flush();
    send_flush();                  // nothing open
  endtask

  // fragmentation at the smallest limit, incl. an interrupted fragment
  task automatic test_fragmentation();
    write_limit(LIMIT_MIN);
    send_unit(3, 40, 0, 0);
    send_unit(4, 16, 0, 0);
    send_unit(3, 30, 0, 0, 20);
    send_unit(3, 4, 1, 4);
    send_unit(3, 4, 1, 4);
    send_flush();
  endtask

  // below-minimum and maximum limits, full-size declared units
  task automatic test_limit_extremes();
    write_limit(16'd0);
    send_unit(3, 20, 0, 0);
    write_limit(16'd15);
    send_unit(4, 14, 0, 0);
    write_limit(16'hFFFF);
    send_unit(3, 10, 1, 16'hFFFF, 12, 16'hFFFF);
    send_unit(4, 3, 0, 0);
  endtask

  // pause sender mid-stream until the pipeline is empty
  task automatic test_drain_pause();
    write_limit(16'd40);
    send_unit(3, 20, 1, 10);
    wait_drained();
    send_unit(4, 12, 0, 0);
    send_flush();
  endtask

  task automatic test_random_traffic();
    int goal, pick, pfx, body, nsize, nsend, usize;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      if ($urandom_range(0, 79) == 0) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0: write_limit(16'd0);
          1: write_limit(LIMIT_MIN);
          2: write_limit(16'hFFFF);
          3: write_limit(LIMIT_RESET);
          default: write_limit(16'($urandom_range(17, 90)));
        endcase
      end
      pfx   = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(3, 4);
      body  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 40);
      nsize = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 65535))
                                          : $urandom_range(5, 30);
      nsend = -1;
      usize = -1;
      if ($urandom_range(0, 9) == 0) nsend = $urandom_range(1, pfx + body);
      if ($urandom_range(0, 19) == 0) usize = $urandom_range(0, 65535);
      send_unit(pfx, body, 1'($urandom), nsize, nsend, usize);
      if ($urandom_range(0, 14) == 0) send_flush();
      if ($urandom_range(0, 29) == 0)
        send_request(1'b0, 8'($urandom), 1'b0, 16'($urandom), 1'($urandom),
                     16'($urandom));
    end
    send_flush();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_units();
    test_bad_and_short();
    test_aggregation();
    test_fragmentation();
    test_limit_extremes();
    test_drain_pause();
    write_limit(LIMIT_RESET);
    test_random_traffic();
    wait_drained();
    $display("covered %0d requests, %0d results: %0d aggregates, %0d fragments, %0d bad",
             items_sent, results_seen, aggs_seen, frags_seen, bad_seen);
    $display("start codes, limits 0/16/40/1400/65535, flushes and cut-short units");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/vnrp_pkg.sv
hdl/vnrp_front.sv
hdl/vnrp_queue.sv
hdl/vnrp_back.sv
hdl/vvc_nal_rtp_packetizer.sv
hdl/vnrp_checker.sv
tb/sv/tb_vvc_nal_rtp_packetizer.sv
